// ----- hw/rtl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the text content classifier
// Byte class constants, UTF-8 decode limits and the decoder state record.
// ----------------------------------------------------------------------------
package tcc_pkg;

   // ASCII control bytes that still count as text
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_VT      = 8'h0B;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CTRL_LIMIT   = 8'd32;

   // Code point limits
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
   localparam logic [20:0] CP_MIN_2B   = 21'h000080;
   localparam logic [20:0] CP_MIN_3B   = 21'h000800;
   localparam logic [20:0] CP_MIN_4B   = 21'h010000;

   // Sequence length codes (total length minus one)
   localparam logic [1:0] SEQ_NONE    = 2'd0;
   localparam logic [1:0] SEQ_TWO     = 2'd1;
   localparam logic [1:0] SEQ_THREE   = 2'd2;
   localparam logic [1:0] SEQ_FOUR    = 2'd3;

   // Decoder state carried from byte to byte
   typedef struct packed {
      logic [1:0]  bytes_pending;
      logic [1:0]  sequence_length;
      logic [20:0] partial_codepoint;
      logic        failed;
   } tcc_state_type;

endpackage

// ----- hw/rtl/tcc_req_if.sv -----
// ----------------------------------------------------------------------------
// tcc_req_if: byte request channel
// Valid/ready channel carrying one buffer byte and its last marker.
// ----------------------------------------------------------------------------
interface tcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/tcc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tcc_rsp_if: verdict response channel
// Valid/ready channel carrying the per-buffer text verdict.
// ----------------------------------------------------------------------------
interface tcc_rsp_if;
   logic valid;
   logic ready;
   logic is_text;

   modport source (output valid, output is_text, input ready);
   modport sink   (input valid, input is_text, output ready);
endinterface

// ----- hw/rtl/tcc_decode.sv -----
// ----------------------------------------------------------------------------
// tcc_decode: single-byte UTF-8 and control character step
// Computes the next decoder state from the current state and one byte.
// ----------------------------------------------------------------------------
module tcc_decode
   import tcc_pkg::*;
(
   input  tcc_state_type state_cur,
   input  logic [7:0]    data_byte,
   output tcc_state_type state_nxt
);

   logic [20:0] shifted_cp;
   logic [20:0] least_cp;
   logic [1:0]  pending_dec;
   logic        is_cont;
   logic        bad_ctrl;

   // Gather continuation bits and pick the overlong bound
   assign shifted_cp  = {state_cur.partial_codepoint[14:0], data_byte[5:0]};
   assign pending_dec = state_cur.bytes_pending - 2'd1;
   assign is_cont     = (data_byte[7:6] == 2'b10);
   assign bad_ctrl    = (data_byte < CTRL_LIMIT) && (data_byte != CHAR_LF) &&
                        (data_byte != CHAR_CR) && (data_byte != CHAR_TAB) &&
                        (data_byte != CHAR_VT);

   always_comb begin
      case (state_cur.sequence_length)
         SEQ_TWO:   least_cp = CP_MIN_2B;
         SEQ_THREE: least_cp = CP_MIN_3B;
         default:   least_cp = CP_MIN_4B;
      endcase
   end

   // Step the decoder; hold everything once the buffer has failed
   always_comb begin
      state_nxt = state_cur;
      if (!state_cur.failed) begin
         if (state_cur.bytes_pending != 2'd0) begin
            if (!is_cont) begin
               state_nxt.failed = 1'b1;
            end else begin
               state_nxt.bytes_pending     = pending_dec;
               state_nxt.partial_codepoint = shifted_cp;
               if (pending_dec == 2'd0) begin
                  if ((shifted_cp < least_cp) || (shifted_cp > CP_MAX) ||
                      (shifted_cp == CP_REPLACE)) begin
                     state_nxt.failed = 1'b1;
                  end
                  state_nxt.partial_codepoint = '0;
                  state_nxt.sequence_length   = SEQ_NONE;
               end
            end
         end else if (!data_byte[7]) begin
            state_nxt.failed = bad_ctrl;
         end else if (data_byte[7:5] == 3'b110) begin
            state_nxt.sequence_length   = SEQ_TWO;
            state_nxt.bytes_pending     = SEQ_TWO;
            state_nxt.partial_codepoint = {16'd0, data_byte[4:0]};
         end else if (data_byte[7:4] == 4'b1110) begin
            state_nxt.sequence_length   = SEQ_THREE;
            state_nxt.bytes_pending     = SEQ_THREE;
            state_nxt.partial_codepoint = {17'd0, data_byte[3:0]};
         end else if (data_byte[7:3] == 5'b11110) begin
            state_nxt.sequence_length   = SEQ_FOUR;
            state_nxt.bytes_pending     = SEQ_FOUR;
            state_nxt.partial_codepoint = {18'd0, data_byte[2:0]};
         end else begin
            state_nxt.failed = 1'b1;
         end
      end
   end

endmodule

// ----- hw/rtl/text_content_classifier.sv -----
// ----------------------------------------------------------------------------
// text_content_classifier: plain text / binary verdict over a byte stream
// Registers each byte, runs one decoder step on it and gives one verdict
// per buffer on the byte marked last.
//
//   channel   direction   payload                  handshake
//   req_bus   in          data_byte, last_byte     valid/ready
//   rsp_bus   out         is_text                  valid/ready
//
// One byte per cycle sustained unless a last byte waits on a held verdict;
// a byte waits in the input register until it retires, and its verdict (if
// last) enters the output register as it retires; the state loop is one step.
// Synchronous reset clears the state and both valid flags.
// A waiting verdict stalls a later last byte and those behind it; others flow.
// ----------------------------------------------------------------------------
module text_content_classifier
   import tcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   tcc_req_if.sink  req_bus,
   tcc_rsp_if.source rsp_bus
);

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   tcc_state_type state_ff;
   tcc_state_type state_in;
   tcc_state_type state_step;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic          out_text_ff;
   logic          retire;
   logic          retire_last;
   logic          req_take;

   // Retire the registered byte unless its verdict has nowhere to go
   assign retire      = in_valid_ff &&
                        (!in_last_ff || !out_valid_ff || rsp_bus.ready);
   assign retire_last = retire && in_last_ff;
   assign req_bus.ready = !in_valid_ff || retire;
   assign req_take    = req_bus.valid && req_bus.ready;

   tcc_decode u_decode (
      .state_cur (state_ff),
      .data_byte (in_byte_ff),
      .state_nxt (state_step)
   );

   // Advance state; clear it after the last byte of a buffer
   always_comb begin
      state_in = state_ff;
      if (retire) begin
         state_in = retire_last ? '0 : state_step;
      end
   end

   // Load the verdict register, drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (retire_last) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= req_take || (in_valid_ff && !retire);
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
      if (retire_last) begin
         out_text_ff <= !state_step.failed && (state_step.bytes_pending == 2'd0);
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.is_text = out_text_ff;

   // Decoder state is back at reset after every verdict
   assert property (@(posedge clock) disable iff (reset)
      retire_last |=> (state_ff == '0))
   else $error("decoder state not cleared after last byte");

   // Never more continuation bytes pending than the sequence holds
   assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_pending <= state_ff.sequence_length)
   else $error("pending count exceeds sequence length");

   // A retired last byte always yields a verdict
   assert property (@(posedge clock) disable iff (reset)
      retire_last |=> out_valid_ff)
   else $error("verdict lost after last byte");

endmodule
